>>> hdl/skba_pkg.sv
// Package for the key sorter: field widths, store geometry and the stored key type.
// Used by the channel interfaces and by sort_keys_by_area.
`default_nettype none

package skba_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int AREA_BITS  = 16;

    localparam int KEY_AREA_W = 16;
    localparam int IDX_W      = 6;
    localparam int AREA_KEEP  = (AREA_BITS < KEY_AREA_W) ? AREA_BITS : KEY_AREA_W;
    localparam int ADDR_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);

    typedef logic [KEY_AREA_W-1:0] t_area;
    typedef logic [IDX_W-1:0]      t_idx;

    typedef struct packed {
        logic [AREA_KEEP-1:0] area;
        t_idx                 index;
    } t_key;

endpackage

`default_nettype wire

>>> hdl/skba_if.sv
// Valid/ready channel interfaces for the key sorter: key input and sorted output.
// Depends on skba_pkg for the payload types.
`default_nettype none

interface skba_in_if;
    logic             valid;
    logic             ready;
    skba_pkg::t_area  key_area;
    skba_pkg::t_idx   record_index;
    logic             is_last;

    modport source (output valid, key_area, record_index, is_last, input ready);
    modport sink   (input valid, key_area, record_index, is_last, output ready);
endinterface

interface skba_out_if;
    logic             valid;
    logic             ready;
    skba_pkg::t_area  sorted_area;
    skba_pkg::t_idx   sorted_index;
    logic             last_out;
    logic             overflow;

    modport source (output valid, sorted_area, sorted_index, last_out, overflow, input ready);
    modport sink   (input valid, sorted_area, sorted_index, last_out, overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/sort_keys_by_area.sv
// Stable ascending sort of keyed entries, built around one single-port-write key memory.
// Depends on skba_pkg and the channel interfaces in skba_if.sv.
//
// Key beats arrive on i_in, one per cycle while the block is loading. Each beat is
// written to the key memory at the current fill position; once the memory is full,
// further beats are dropped and the set is flagged as overflowed. A beat with is_last
// ends the set and starts the sort (one key alone goes straight to emission); i_in.ready
// stays low until every result beat has been handed to the output register.
// The sort walks each pass from the back toward the front with the running minimum
// held in a register, doing one memory read and one write per cycle. Each pass reads
// the back entry, loads it as the running minimum, walks toward the front writing the
// non-minimum key back at each position, and then writes the minimum at the front.
// Emission reads one key at a time into the output register and reads the next only once
// that register is free; a stalled receiver holds the output register and the read-out.
// After the last result is registered, loading of the next set starts at once.
// Reset clears the fill count, the overflow flag and all handshake state; the memory
// holds no reset value and only positions written in the current set are read.
`default_nettype none

module sort_keys_by_area (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    skba_in_if.sink     i_in,
    skba_out_if.source  o_out
);
    import skba_pkg::*;

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_PSTART  = 3'd1;
    localparam logic [2:0] S_PFIRST  = 3'd2;
    localparam logic [2:0] S_WALK    = 3'd3;
    localparam logic [2:0] S_PEND    = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;
    localparam logic [2:0] S_EMIT_LD = 3'd6;

    t_key              r_mem [MAX_KEYS];
    t_key              r_rdata;

    logic [2:0]        r_state,    n_state;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic              r_dropped,  n_dropped;
    logic [ADDR_W-1:0] r_pass,     n_pass;
    logic [ADDR_W-1:0] r_pos,      n_pos;
    logic [ADDR_W-1:0] r_k,        n_k;
    t_key              r_carry,    n_carry;
    t_key              r_out,      n_out;
    logic              r_out_last, n_out_last;
    logic              r_out_ovf,  n_out_ovf;
    logic              r_ov,       n_ov;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_key              mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [ADDR_W-1:0] last_idx;
    logic [ADDR_W-1:0] pos_m1;
    logic [CNT_W-1:0]  cnt_new;
    logic              out_free;

    assign last_idx = ADDR_W'(r_count - CNT_W'(1));
    assign pos_m1   = r_pos - ADDR_W'(1);
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_pass     = r_pass;
        n_pos      = r_pos;
        n_k        = r_k;
        n_carry    = r_carry;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        n_ov       = r_ov && !o_out.ready;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = r_carry;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        cnt_new    = r_count;

        unique case (r_state)
            S_LOAD: begin
                if (i_in.valid) begin
                    if (r_count < CNT_W'(MAX_KEYS)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[ADDR_W-1:0];
                        mem_wdata = '{area: i_in.key_area[AREA_KEEP-1:0],
                                      index: i_in.record_index};
                        cnt_new   = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    n_count = cnt_new;
                    if (i_in.is_last) begin
                        n_pass = '0;
                        n_k    = '0;
                        if (cnt_new >= CNT_W'(2)) begin
                            n_state = S_PSTART;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_PSTART: begin
                mem_re    = 1'b1;
                mem_raddr = last_idx;
                n_pos     = last_idx;
                n_state   = S_PFIRST;
            end
            S_PFIRST: begin
                n_carry   = r_rdata;
                mem_re    = 1'b1;
                mem_raddr = pos_m1;
                n_state   = S_WALK;
            end
            S_WALK: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                if (r_carry.area < r_rdata.area) begin
                    mem_wdata = r_rdata;
                end else begin
                    mem_wdata = r_carry;
                    n_carry   = r_rdata;
                end
                n_pos = pos_m1;
                if (pos_m1 > r_pass) begin
                    mem_re    = 1'b1;
                    mem_raddr = pos_m1 - ADDR_W'(1);
                end else begin
                    n_state = S_PEND;
                end
            end
            S_PEND: begin
                mem_we    = 1'b1;
                mem_waddr = r_pass;
                mem_wdata = r_carry;
                n_pass    = r_pass + ADDR_W'(1);
                if (CNT_W'(r_pass) + CNT_W'(2) >= r_count) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_PSTART;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k;
                    n_state   = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                n_out      = r_rdata;
                n_out_last = (r_k == last_idx);
                n_out_ovf  = r_dropped;
                n_ov       = 1'b1;
                if (r_k == last_idx) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                    n_state   = S_LOAD;
                end else begin
                    n_k     = r_k + ADDR_W'(1);
                    n_state = S_EMIT;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_ov      <= n_ov;
        end
        r_pass     <= n_pass;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_carry    <= n_carry;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign i_in.ready         = (r_state == S_LOAD);
    assign o_out.valid        = r_ov;
    assign o_out.sorted_area  = KEY_AREA_W'(r_out.area);
    assign o_out.sorted_index = r_out.index;
    assign o_out.last_out     = r_out_last;
    assign o_out.overflow     = r_out_ovf;

    // The walk never reads the entry it writes in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("key memory read and write hit the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("fill count beyond capacity");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_pos > r_pass))
        else $error("pass walked past its front position");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LD && r_k == last_idx)
            |=> (r_state == S_LOAD && r_count == '0 && !r_dropped && o_out.last_out))
        else $error("set did not close after its final result");

endmodule

`default_nettype wire
